[sv/aapl_pkg.sv]
// ---------------------------------------------------------------------------
// aapl_pkg
// Beat types, pipeline stage types and digit-step functions shared by the
// analytic amplitude/phase blend pipeline.
// ---------------------------------------------------------------------------
package aapl_pkg;

  // Pixel value 1.0 in Q1.15
  localparam logic [15:0] PIX_ONE = 16'h8000;

  // Number of pipeline steps per iterative unit
  localparam int RT32_STEPS = 16;
  localparam int UDIV_STEPS = 31;
  localparam int RT62_STEPS = 31;
  localparam int PDIV_STEPS = 15;

  typedef struct packed {
    logic signed [15:0] before_real;
    logic signed [15:0] before_imag;
    logic signed [15:0] after_real;
    logic signed [15:0] after_imag;
    logic        [15:0] blend_weight;
    logic               row_last;
  } sample_t;

  typedef struct packed {
    logic [15:0] pixel_out;
    logic        row_end;
  } result_t;

  // Square root state, 32-bit radicand, 16-bit root
  typedef struct packed {
    logic [31:0] rad;
    logic [17:0] rem;
    logic [15:0] root;
  } rt32_t;

  // Square root state, 62-bit radicand, 31-bit root
  typedef struct packed {
    logic [61:0] rad;
    logic [32:0] rem;
    logic [30:0] root;
  } rt62_t;

  // Unit phasor divider state: remaining dividend bits, remainder, quotient
  typedef struct packed {
    logic [30:0] d;
    logic [15:0] rem;
    logic [30:0] q;
  } udiv_t;

  // Output divider state
  typedef struct packed {
    logic [14:0] nv;
    logic [30:0] rem;
    logic [14:0] q;
  } pdiv_t;

  // One root digit per call
  function automatic rt32_t rt32_step(rt32_t s);
    rt32_t       o;
    logic [17:0] r2;
    logic [17:0] t;
    r2 = {s.rem[15:0], s.rad[31:30]};
    t  = {s.root, 2'b01};
    o.rad = {s.rad[29:0], 2'b00};
    if (r2 >= t) begin
      o.rem  = r2 - t;
      o.root = {s.root[14:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {s.root[14:0], 1'b0};
    end
    return o;
  endfunction

  function automatic rt62_t rt62_step(rt62_t s);
    rt62_t       o;
    logic [32:0] r2;
    logic [32:0] t;
    r2 = {s.rem[30:0], s.rad[61:60]};
    t  = {s.root[30:0], 2'b01};
    o.rad = {s.rad[59:0], 2'b00};
    if (r2 >= t) begin
      o.rem  = r2 - t;
      o.root = {s.root[29:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {s.root[29:0], 1'b0};
    end
    return o;
  endfunction

  // One quotient bit per call, remainder stays below m
  function automatic udiv_t udiv_step(udiv_t s, logic [15:0] m);
    udiv_t       o;
    logic [16:0] r2;
    logic [16:0] diff;
    logic        ge;
    r2   = {s.rem, s.d[30]};
    diff = r2 - {1'b0, m};
    ge   = (r2 >= {1'b0, m});
    o.d   = {s.d[29:0], 1'b0};
    o.q   = {s.q[29:0], ge};
    o.rem = ge ? diff[15:0] : r2[15:0];
    return o;
  endfunction

  function automatic pdiv_t pdiv_step(pdiv_t s, logic [30:0] n);
    pdiv_t       o;
    logic [31:0] r2;
    logic [31:0] diff;
    logic        ge;
    r2   = {s.rem, s.nv[14]};
    diff = r2 - {1'b0, n};
    ge   = (r2 >= {1'b0, n});
    o.nv  = {s.nv[13:0], 1'b0};
    o.q   = {s.q[13:0], ge};
    o.rem = ge ? diff[30:0] : r2[30:0];
    return o;
  endfunction

endpackage

[sv/analytic_amplitude_phase_lerp.sv]
// Throughput: one beat per cycle while sample_stall is low; every root digit
// and quotient bit has a stage of its own, so no unit is shared between beats.
// A held result is parked in a one-entry skid register; sample_stall rises
// only while that register is full, and the whole pipeline then holds.
// Reset (rst, synchronous) clears all valid bits; payload is not reset.
// ---------------------------------------------------------------------------
// analytic_amplitude_phase_lerp
// Blends magnitude and normalized phasor of two analytic pixels and outputs the
// blended magnitude times the real part of the renormalized blended phasor,
// in Q1.15.
module analytic_amplitude_phase_lerp
  import aapl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  output logic    sample_stall,
  input  sample_t sample,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  // Stage types local to the pipeline
  typedef struct packed {
    logic [3:0][30:0] sq;
    logic [3:0]       neg;
    logic [3:0][15:0] mag;
    logic [15:0]      a;
    logic             last;
  } sq_t;

  typedef struct packed {
    rt32_t [1:0]      s;
    logic [3:0]       neg;
    logic [3:0][15:0] mag;
    logic [15:0]      a;
    logic             last;
  } rt_t;

  typedef struct packed {
    udiv_t [3:0] ln;
    logic [3:0]  neg;
    logic [15:0] m0;
    logic [15:0] m1;
    logic [15:0] a;
    logic        last;
  } dv_t;

  typedef struct packed {
    logic signed [31:0] u0r;
    logic signed [31:0] u0i;
    logic signed [31:0] u1r;
    logic signed [31:0] u1i;
    logic [15:0]        m0;
    logic [15:0]        m1;
    logic [15:0]        a;
    logic               last;
  } un_t;

  typedef struct packed {
    logic signed [31:0] u0r;
    logic signed [31:0] u0i;
    logic [15:0]        m0;
    logic signed [32:0] dr;
    logic signed [32:0] di;
    logic signed [16:0] dm;
    logic [15:0]        a;
    logic               last;
  } df_t;

  typedef struct packed {
    logic signed [31:0] u0r;
    logic signed [31:0] u0i;
    logic [15:0]        m0;
    logic signed [49:0] pr;
    logic signed [49:0] pi;
    logic signed [33:0] pm;
    logic               last;
  } pr_t;

  typedef struct packed {
    logic signed [31:0] br;
    logic signed [31:0] bi;
    logic [15:0]        amp;
    logic               last;
  } bl_t;

  typedef struct packed {
    logic [60:0] sqr;
    logic [60:0] sqi;
    logic [47:0] num;
    logic        pos;
    logic        last;
  } ns_t;

  typedef struct packed {
    rt62_t       s;
    logic [47:0] num;
    logic        pos;
    logic        last;
  } nr_t;

  typedef struct packed {
    pdiv_t       p;
    logic [30:0] n;
    logic        sat;
    logic        pos;
    logic        last;
  } pd_t;

  // Pipeline registers and their valid bits
  sq_t a_q;
  logic a_v;
  rt_t b_q [RT32_STEPS+1];
  logic [RT32_STEPS:0] b_v;
  dv_t c_q [UDIV_STEPS+1];
  logic [UDIV_STEPS:0] c_v;
  un_t u_q;
  df_t d_q;
  pr_t p_q;
  bl_t l_q;
  logic [3:0] dl_v;
  ns_t e_q;
  logic e_v;
  nr_t f_q [RT62_STEPS+1];
  logic [RT62_STEPS:0] f_v;
  pd_t g_q [PDIV_STEPS+1];
  logic [PDIV_STEPS:0] g_v;

  // Output and skid registers
  logic    o_v;
  result_t o_d;
  logic    s_v;
  result_t s_d;

  logic    en;
  logic    take;
  result_t p_d;

  // Next values of each phase's first stage
  sq_t a_next;
  rt_t b_next;
  dv_t c_next;
  un_t u_next;
  df_t d_next;
  pr_t p_next;
  bl_t l_next;
  ns_t e_next;
  nr_t f_next;
  pd_t g_next;

  // Stage contents after one digit step
  rt_t b_adv [1:RT32_STEPS];
  dv_t c_adv [1:UDIV_STEPS];
  nr_t f_adv [1:RT62_STEPS];
  pd_t g_adv [1:PDIV_STEPS];

  logic signed [15:0] comp [4];
  logic signed [31:0] prod [4];
  logic signed [16:0] aw;
  logic signed [49:0] sum_r;
  logic signed [49:0] sum_i;
  logic signed [33:0] sum_m;
  logic [31:0]        mag_r;
  logic [31:0]        mag_i;
  logic [46:0]        amp_br;

  assign en           = !s_v;
  assign take         = o_v && !result_stall;
  assign sample_stall = s_v;
  assign result_valid = o_v;
  assign result       = o_d;

  // Squares of the four components, signs and magnitudes
  always_comb begin
    comp[0] = sample.before_real;
    comp[1] = sample.before_imag;
    comp[2] = sample.after_real;
    comp[3] = sample.after_imag;
    for (int k = 0; k < 4; k++) begin
      prod[k]       = 32'(comp[k]) * 32'(comp[k]);
      a_next.sq[k]  = prod[k][30:0];
      a_next.neg[k] = comp[k][15];
      a_next.mag[k] = comp[k][15] ? (16'd0 - comp[k]) : comp[k];
    end
    a_next.a    = sample.blend_weight;
    a_next.last = sample.row_last;
  end

  // Sum of squares loads the magnitude roots
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      b_next.s[k].rad  = {1'b0, a_q.sq[2*k]} + {1'b0, a_q.sq[2*k+1]};
      b_next.s[k].rem  = '0;
      b_next.s[k].root = '0;
    end
    b_next.neg  = a_q.neg;
    b_next.mag  = a_q.mag;
    b_next.a    = a_q.a;
    b_next.last = a_q.last;
  end

  // Load the unit phasor dividers with |c| << 30
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      c_next.ln[k].rem = {1'b0, b_q[RT32_STEPS].mag[k][15:1]};
      c_next.ln[k].d   = {b_q[RT32_STEPS].mag[k][0], 30'd0};
      c_next.ln[k].q   = '0;
    end
    c_next.neg  = b_q[RT32_STEPS].neg;
    c_next.m0   = b_q[RT32_STEPS].s[0].root;
    c_next.m1   = b_q[RT32_STEPS].s[1].root;
    c_next.a    = b_q[RT32_STEPS].a;
    c_next.last = b_q[RT32_STEPS].last;
  end

  // Apply signs, zero the phasor of a zero vector
  function automatic logic signed [31:0] unit_val(logic [30:0] q, logic neg, logic [15:0] m);
    logic [31:0] v;
    v = {1'b0, q};
    if (m == 16'd0) begin
      v = '0;
    end else if (neg) begin
      v = 32'd0 - v;
    end
    return v;
  endfunction

  always_comb begin
    u_next.u0r  = unit_val(c_q[UDIV_STEPS].ln[0].q, c_q[UDIV_STEPS].neg[0], c_q[UDIV_STEPS].m0);
    u_next.u0i  = unit_val(c_q[UDIV_STEPS].ln[1].q, c_q[UDIV_STEPS].neg[1], c_q[UDIV_STEPS].m0);
    u_next.u1r  = unit_val(c_q[UDIV_STEPS].ln[2].q, c_q[UDIV_STEPS].neg[2], c_q[UDIV_STEPS].m1);
    u_next.u1i  = unit_val(c_q[UDIV_STEPS].ln[3].q, c_q[UDIV_STEPS].neg[3], c_q[UDIV_STEPS].m1);
    u_next.m0   = c_q[UDIV_STEPS].m0;
    u_next.m1   = c_q[UDIV_STEPS].m1;
    u_next.a    = c_q[UDIV_STEPS].a;
    u_next.last = c_q[UDIV_STEPS].last;
  end

  // Differences for the three blends
  always_comb begin
    d_next.u0r  = u_q.u0r;
    d_next.u0i  = u_q.u0i;
    d_next.m0   = u_q.m0;
    d_next.dr   = 33'(u_q.u1r) - 33'(u_q.u0r);
    d_next.di   = 33'(u_q.u1i) - 33'(u_q.u0i);
    d_next.dm   = $signed({1'b0, u_q.m1}) - $signed({1'b0, u_q.m0});
    d_next.a    = u_q.a;
    d_next.last = u_q.last;
  end

  // Weight times difference
  always_comb begin
    aw          = $signed({1'b0, d_q.a});
    p_next.u0r  = d_q.u0r;
    p_next.u0i  = d_q.u0i;
    p_next.m0   = d_q.m0;
    p_next.pr   = 50'(aw) * 50'(d_q.dr);
    p_next.pi   = 50'(aw) * 50'(d_q.di);
    p_next.pm   = 34'(aw) * 34'(d_q.dm);
    p_next.last = d_q.last;
  end

  // Floor shift and add the low end
  always_comb begin
    sum_r       = 50'(p_q.u0r) + (p_q.pr >>> 16);
    sum_i       = 50'(p_q.u0i) + (p_q.pi >>> 16);
    sum_m       = $signed({18'd0, p_q.m0}) + (p_q.pm >>> 16);
    l_next.br   = sum_r[31:0];
    l_next.bi   = sum_i[31:0];
    l_next.amp  = sum_m[15:0];
    l_next.last = p_q.last;
  end

  // Squares of the blended phasor and the output numerator
  always_comb begin
    mag_r       = l_q.br[31] ? (32'd0 - l_q.br) : l_q.br;
    mag_i       = l_q.bi[31] ? (32'd0 - l_q.bi) : l_q.bi;
    amp_br      = 47'(l_q.amp) * 47'(mag_r[30:0]);
    e_next.pos  = !l_q.br[31] && (l_q.br != 32'sd0);
    e_next.sqr  = 61'(mag_r[30:0]) * 61'(mag_r[30:0]);
    e_next.sqi  = 61'(mag_i[30:0]) * 61'(mag_i[30:0]);
    e_next.num  = e_next.pos ? {amp_br, 1'b0} : 48'd0;
    e_next.last = l_q.last;
  end

  always_comb begin
    f_next.s.rad  = {1'b0, e_q.sqr} + {1'b0, e_q.sqi};
    f_next.s.rem  = '0;
    f_next.s.root = '0;
    f_next.num    = e_q.num;
    f_next.pos    = e_q.pos;
    f_next.last   = e_q.last;
  end

  // Saturation test, then the divider gets the bits below it
  always_comb begin
    g_next.n     = f_q[RT62_STEPS].s.root;
    g_next.sat   = f_q[RT62_STEPS].num >= {2'd0, f_q[RT62_STEPS].s.root, 15'd0};
    g_next.p.rem = f_q[RT62_STEPS].num[45:15];
    g_next.p.nv  = f_q[RT62_STEPS].num[14:0];
    g_next.p.q   = '0;
    g_next.pos   = f_q[RT62_STEPS].pos;
    g_next.last  = f_q[RT62_STEPS].last;
  end

  // One digit step per stage of each iterative unit
  always_comb begin
    for (int k = 1; k <= RT32_STEPS; k++) begin
      b_adv[k]      = b_q[k-1];
      b_adv[k].s[0] = rt32_step(b_q[k-1].s[0]);
      b_adv[k].s[1] = rt32_step(b_q[k-1].s[1]);
    end
    for (int k = 1; k <= UDIV_STEPS; k++) begin
      c_adv[k]       = c_q[k-1];
      c_adv[k].ln[0] = udiv_step(c_q[k-1].ln[0], c_q[k-1].m0);
      c_adv[k].ln[1] = udiv_step(c_q[k-1].ln[1], c_q[k-1].m0);
      c_adv[k].ln[2] = udiv_step(c_q[k-1].ln[2], c_q[k-1].m1);
      c_adv[k].ln[3] = udiv_step(c_q[k-1].ln[3], c_q[k-1].m1);
    end
    for (int k = 1; k <= RT62_STEPS; k++) begin
      f_adv[k]   = f_q[k-1];
      f_adv[k].s = rt62_step(f_q[k-1].s);
    end
    for (int k = 1; k <= PDIV_STEPS; k++) begin
      g_adv[k]   = g_q[k-1];
      g_adv[k].p = pdiv_step(g_q[k-1].p, g_q[k-1].n);
    end
  end

  // Final pixel value
  always_comb begin
    if (!g_q[PDIV_STEPS].pos) begin
      p_d.pixel_out = '0;
    end else if (g_q[PDIV_STEPS].sat) begin
      p_d.pixel_out = PIX_ONE;
    end else begin
      p_d.pixel_out = {1'b0, g_q[PDIV_STEPS].p.q};
    end
    p_d.row_end = g_q[PDIV_STEPS].last;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v  <= 1'b0;
      b_v  <= '0;
      c_v  <= '0;
      dl_v <= '0;
      e_v  <= 1'b0;
      f_v  <= '0;
      g_v  <= '0;
    end else if (en) begin
      a_v  <= sample_valid;
      b_v  <= {b_v[RT32_STEPS-1:0], a_v};
      c_v  <= {c_v[UDIV_STEPS-1:0], b_v[RT32_STEPS]};
      dl_v <= {dl_v[2:0], c_v[UDIV_STEPS]};
      e_v  <= dl_v[3];
      f_v  <= {f_v[RT62_STEPS-1:0], e_v};
      g_v  <= {g_v[PDIV_STEPS-1:0], f_v[RT62_STEPS]};
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      a_q    <= a_next;
      b_q[0] <= b_next;
      for (int k = 1; k <= RT32_STEPS; k++) begin
        b_q[k] <= b_adv[k];
      end
      c_q[0] <= c_next;
      for (int k = 1; k <= UDIV_STEPS; k++) begin
        c_q[k] <= c_adv[k];
      end
      u_q    <= u_next;
      d_q    <= d_next;
      p_q    <= p_next;
      l_q    <= l_next;
      e_q    <= e_next;
      f_q[0] <= f_next;
      for (int k = 1; k <= RT62_STEPS; k++) begin
        f_q[k] <= f_adv[k];
      end
      g_q[0] <= g_next;
      for (int k = 1; k <= PDIV_STEPS; k++) begin
        g_q[k] <= g_adv[k];
      end
    end
  end

  // Output register with one-entry skid
  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
      s_v <= 1'b0;
    end else if (s_v) begin
      if (take) begin
        o_d <= s_d;
        s_v <= 1'b0;
      end
    end else if (g_v[PDIV_STEPS]) begin
      if (!o_v || take) begin
        o_v <= 1'b1;
        o_d <= p_d;
      end else begin
        s_v <= 1'b1;
        s_d <= p_d;
      end
    end else if (take) begin
      o_v <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  // Skid holds a beat only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    s_v |-> o_v)
    else $error("skid full while output register empty");

  // Skid fills only when the output beat was held
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(s_v) |-> $past(o_v && result_stall))
    else $error("skid filled without a held output beat");

  // Pipeline holds while the skid is full
  a_pipe_hold: assert property (@(posedge clk) disable iff (rst)
    s_v |=> (g_v == $past(g_v)) && (b_v == $past(b_v)))
    else $error("pipeline moved while held");

  // Pixel never exceeds 1.0
  a_pix_range: assert property (@(posedge clk) disable iff (rst)
    o_v |-> (o_d.pixel_out <= PIX_ONE))
    else $error("pixel above one");
`endif

endmodule
